### rtl/core/tssv_pkg.sv
`timescale 1ns / 1ps
package tssv_pkg;

  // Parse phase of the current file
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKENS,
    PH_FOOTER,
    PH_COMPLETE,
    PH_HALTED
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    CS_RUN,
    CS_DIV,
    CS_CHK
  } ctrl_state_t;

  // Status codes
  localparam logic [2:0] SC_OK       = 3'd0;
  localparam logic [2:0] SC_CORRUPT  = 3'd1;
  localparam logic [2:0] SC_VERSION  = 3'd2;
  localparam logic [2:0] SC_CONFIG   = 3'd3;
  localparam logic [2:0] SC_OVERFLOW = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_VOCAB = 3'd0;
  localparam logic [2:0] REG_ID0   = 3'd1;
  localparam logic [2:0] REG_ID1   = 3'd2;
  localparam logic [2:0] REG_ID2   = 3'd3;
  localparam logic [2:0] REG_ID3   = 3'd4;
  localparam logic [2:0] REG_BOS   = 3'd5;
  localparam logic [2:0] REG_EOS   = 3'd6;

  localparam int unsigned CFG_W     = 64;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Header layout, byte offsets
  localparam logic [6:0] HDR_VER   = 7'd8;
  localparam logic [6:0] HDR_FLAGS = 7'd12;
  localparam logic [6:0] HDR_SEQ   = 7'd16;
  localparam logic [6:0] HDR_TCNT  = 7'd24;
  localparam logic [6:0] HDR_SCNT  = 7'd32;
  localparam logic [6:0] HDR_ID    = 7'd40;
  localparam logic [6:0] HDR_LAST  = 7'd71;

  // File mark, first byte in the low bits
  localparam logic [63:0] SHARD_MARK = 64'h4452_5348_4159_494E;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

  // Command from controller to datapath
  typedef struct packed {
    logic byte_en;
    logic div_load;
    logic div_step;
    logic chk;
  } tssv_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hdr_last;
    logic out_busy;
  } tssv_sts_t;

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/tssv_ctrl.sv
`timescale 1ns / 1ps
module tssv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tssv_pkg::tssv_sts_t sts,
  output tssv_pkg::tssv_cmd_t cmd,
  output logic                in_stall
);
  import tssv_pkg::*;

  ctrl_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  accept;

  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      CS_RUN: begin
        if (accept && sts.hdr_last) begin
          state_nxt = CS_DIV;
          cnt_nxt   = '0;
        end
      end
      CS_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = CS_CHK;
      end
      CS_CHK: begin
        if (!sts.out_busy) state_nxt = CS_RUN;
      end
      default: state_nxt = CS_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      CS_RUN: begin
        in_stall     = sts.out_busy;
        cmd.byte_en  = in_valid && !sts.out_busy;
        cmd.div_load = in_valid && !sts.out_busy && sts.hdr_last;
      end
      CS_DIV: cmd.div_step = 1'b1;
      CS_CHK: cmd.chk = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/tssv_datapath.sv
`timescale 1ns / 1ps
module tssv_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tssv_pkg::tssv_cmd_t    cmd,
  output tssv_pkg::tssv_sts_t    sts,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_file,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [tssv_pkg::CFG_W-1:0] cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_token_valid,
  output logic [31:0]            out_token_value,
  output logic                   out_status_valid,
  output logic [2:0]             out_status_code
);
  import tssv_pkg::*;

  // Configuration
  logic [32:0] vocab_r;
  logic [63:0] id_r [4];
  logic [31:0] bos_r, eos_r;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        id_ok_r, id_ok_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [63:0] tcnt_r, tcnt_nxt;
  logic [63:0] scnt_r, scnt_nxt;
  logic [63:0] seen_r, seen_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] latest_r, latest_nxt;
  logic [63:0] foot_r, foot_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        pend_r, pend_nxt;

  // Divider
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [64:0] trial;
  logic        trial_ge;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        otv_r, otv_nxt;
  logic [31:0] otok_r, otok_nxt;
  logic        osv_r, osv_nxt;
  logic [2:0]  osc_r, osc_nxt;

  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [4:0]  id_k;
  logic [7:0]  id_want;
  logic [31:0] tok_v;
  logic [63:0] foot_v;
  logic [63:0] seen_inc;
  logic        tok_emit;
  logic        finish;
  logic [2:0]  status;
  logic [2:0]  hdr_err;

  assign b        = in_data_byte;
  assign crc_upd  = crc_byte(crc_r, b);
  assign id_k     = 5'(idx_r - HDR_ID);
  assign id_want  = id_r[id_k[4:3]][{id_k[2:0], 3'b000} +: 8];
  assign seen_inc = seen_r + 64'd1;

  assign sts.hdr_last = (phase_r == PH_HEADER) && (idx_r == HDR_LAST);
  assign sts.out_busy = out_valid_r && out_stall;

  // Header checks, in priority order
  always_comb begin
    priority if (!magic_ok_r)                       hdr_err = SC_CORRUPT;
    else if (ver_r != 32'd1)                        hdr_err = SC_VERSION;
    else if (flags_r != 32'd0 || seq_r == 64'd0 ||
             tcnt_r < 64'd2 || scnt_r == 64'd0)     hdr_err = SC_CORRUPT;
    else if (scnt_r != quo_r + 64'd1)               hdr_err = SC_CORRUPT;
    else if (!id_ok_r)                              hdr_err = SC_CONFIG;
    else if (tcnt_r[63:62] != 2'b00)                hdr_err = SC_OVERFLOW;
    else if (vocab_r == 33'd0)                      hdr_err = SC_CONFIG;
    else                                            hdr_err = SC_OK;
  end

  // Parse one byte, or finish the header checks
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    magic_ok_nxt = magic_ok_r;
    id_ok_nxt    = id_ok_r;
    ver_nxt      = ver_r;
    flags_nxt    = flags_r;
    seq_nxt      = seq_r;
    tcnt_nxt     = tcnt_r;
    scnt_nxt     = scnt_r;
    seen_nxt     = seen_r;
    asm_nxt      = asm_r;
    crc_nxt      = crc_r;
    first_nxt    = first_r;
    latest_nxt   = latest_r;
    foot_nxt     = foot_r;
    err_nxt      = err_r;
    pend_nxt     = pend_r;
    tok_v        = asm_r;
    foot_v       = foot_r;
    tok_emit     = 1'b0;
    finish       = 1'b0;
    status       = SC_OK;

    if (cmd.byte_en) begin
      tok_v[{idx_r[1:0], 3'b000} +: 8]  = b;
      foot_v[{idx_r[2:0], 3'b000} +: 8] = b;
      unique case (phase_r)
        PH_HEADER: begin
          crc_nxt = crc_upd;
          priority if (idx_r < HDR_VER) begin
            if (b != SHARD_MARK[{idx_r[2:0], 3'b000} +: 8]) magic_ok_nxt = 1'b0;
          end else if (idx_r < HDR_FLAGS) begin
            ver_nxt[{idx_r[1:0], 3'b000} +: 8] = b;
          end else if (idx_r < HDR_SEQ) begin
            flags_nxt[{idx_r[1:0], 3'b000} +: 8] = b;
          end else if (idx_r < HDR_TCNT) begin
            seq_nxt[{idx_r[2:0], 3'b000} +: 8] = b;
          end else if (idx_r < HDR_SCNT) begin
            tcnt_nxt[{idx_r[2:0], 3'b000} +: 8] = b;
          end else if (idx_r < HDR_ID) begin
            scnt_nxt[{idx_r[2:0], 3'b000} +: 8] = b;
          end else begin
            if (b != id_want) id_ok_nxt = 1'b0;
          end
          if (idx_r != HDR_LAST) begin
            idx_nxt = idx_r + 7'd1;
          end else begin
            // hold end of file until the checks are done
            idx_nxt  = '0;
            pend_nxt = in_end_of_file;
          end
        end
        PH_TOKENS: begin
          crc_nxt = crc_upd;
          if (idx_r[1:0] != 2'd3) begin
            idx_nxt = idx_r + 7'd1;
            asm_nxt = tok_v;
          end else begin
            idx_nxt = '0;
            asm_nxt = '0;
            if ({1'b0, tok_v} >= vocab_r) begin
              err_nxt   = SC_CORRUPT;
              phase_nxt = PH_HALTED;
            end else begin
              tok_emit   = 1'b1;
              if (seen_r == 64'd0) first_nxt = tok_v;
              latest_nxt = tok_v;
              seen_nxt   = seen_inc;
              if (seen_inc >= tcnt_r) phase_nxt = PH_FOOTER;
            end
          end
        end
        PH_FOOTER: begin
          if (idx_r[2:0] != 3'd7) begin
            idx_nxt  = idx_r + 7'd1;
            foot_nxt = foot_v;
          end else begin
            idx_nxt  = '0;
            foot_nxt = foot_v;
            if (foot_v[31:0] != 32'd1 || foot_v[63:32] != ~crc_r) begin
              err_nxt   = SC_CORRUPT;
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt = PH_COMPLETE;
            end
          end
        end
        PH_COMPLETE: begin
          err_nxt   = SC_CORRUPT;
          phase_nxt = PH_HALTED;
        end
        default: ;
      endcase

      // end of file: report and start over
      if (in_end_of_file && !sts.hdr_last) begin
        finish = 1'b1;
        priority if (err_nxt != SC_OK)                     status = err_nxt;
        else if (phase_nxt != PH_COMPLETE)                 status = SC_CORRUPT;
        else if (first_nxt != bos_r || latest_nxt != eos_r) status = SC_CONFIG;
        else                                               status = SC_OK;
      end
    end else if (cmd.chk) begin
      if (hdr_err != SC_OK) begin
        err_nxt   = hdr_err;
        phase_nxt = PH_HALTED;
      end else begin
        phase_nxt = PH_TOKENS;
      end
      if (pend_r) begin
        finish = 1'b1;
        status = (hdr_err != SC_OK) ? hdr_err : SC_CORRUPT;
      end
    end

    if (finish) begin
      phase_nxt    = PH_HEADER;
      idx_nxt      = '0;
      magic_ok_nxt = 1'b1;
      id_ok_nxt    = 1'b1;
      ver_nxt      = '0;
      flags_nxt    = '0;
      seq_nxt      = '0;
      tcnt_nxt     = '0;
      scnt_nxt     = '0;
      seen_nxt     = '0;
      asm_nxt      = '0;
      crc_nxt      = CRC_PRESET;
      first_nxt    = '0;
      latest_nxt   = '0;
      foot_nxt     = '0;
      err_nxt      = SC_OK;
      pend_nxt     = 1'b0;
    end
  end

  // Restoring divider, one quotient bit per step
  assign trial    = {rem_r, quo_r[63]};
  assign trial_ge = trial >= {1'b0, seq_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_load) begin
      rem_nxt = '0;
      quo_nxt = tcnt_r - 64'd2;
    end else if (cmd.div_step) begin
      rem_nxt = trial_ge ? 64'(trial - {1'b0, seq_r}) : trial[63:0];
      quo_nxt = {quo_r[62:0], trial_ge};
    end
  end

  // Load a request into the output register, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    otv_nxt       = otv_r;
    otok_nxt      = otok_r;
    osv_nxt       = osv_r;
    osc_nxt       = osc_r;
    if (tok_emit || finish) begin
      out_valid_nxt = 1'b1;
      otv_nxt       = tok_emit;
      otok_nxt      = tok_emit ? tok_v : 32'd0;
      osv_nxt       = finish;
      osc_nxt       = finish ? status : SC_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_valid  = otv_r;
  assign out_token_value  = otok_r;
  assign out_status_valid = osv_r;
  assign out_status_code  = osc_r;

  // Control and parse registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= '0;
      magic_ok_r  <= 1'b1;
      id_ok_r     <= 1'b1;
      ver_r       <= '0;
      flags_r     <= '0;
      seq_r       <= '0;
      tcnt_r      <= '0;
      scnt_r      <= '0;
      seen_r      <= '0;
      asm_r       <= '0;
      crc_r       <= CRC_PRESET;
      first_r     <= '0;
      latest_r    <= '0;
      foot_r      <= '0;
      err_r       <= SC_OK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      magic_ok_r  <= magic_ok_nxt;
      id_ok_r     <= id_ok_nxt;
      ver_r       <= ver_nxt;
      flags_r     <= flags_nxt;
      seq_r       <= seq_nxt;
      tcnt_r      <= tcnt_nxt;
      scnt_r      <= scnt_nxt;
      seen_r      <= seen_nxt;
      asm_r       <= asm_nxt;
      crc_r       <= crc_nxt;
      first_r     <= first_nxt;
      latest_r    <= latest_nxt;
      foot_r      <= foot_nxt;
      err_r       <= err_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    otv_r  <= otv_nxt;
    otok_r <= otok_nxt;
    osv_r  <= osv_nxt;
    osc_r  <= osc_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_r <= '0;
      id_r[0] <= '0;
      id_r[1] <= '0;
      id_r[2] <= '0;
      id_r[3] <= '0;
      bos_r   <= 32'd1;
      eos_r   <= 32'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOCAB: vocab_r <= cfg_data[32:0];
        REG_ID0:   id_r[0] <= cfg_data;
        REG_ID1:   id_r[1] <= cfg_data;
        REG_ID2:   id_r[2] <= cfg_data;
        REG_ID3:   id_r[3] <= cfg_data;
        REG_BOS:   bos_r   <= cfg_data[31:0];
        REG_EOS:   eos_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/token_shard_stream_validator_top.sv
`timescale 1ns / 1ps
// Results are registered in the output register. Throughput: one byte per cycle
// while the output is not stalled, except after the last header byte, where input
// stalls while the 64-step shift-subtract divider checks the sample count.
// Reset: synchronous active-low rst_n clears parse state and the output valid flag
// and returns the registers to vocab 0, identity 0, BOS token 1, EOS token 2.
module token_shard_stream_validator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_file,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [tssv_pkg::CFG_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_token_valid,
  output logic [31:0]                out_token_value,
  output logic                       out_status_valid,
  output logic [2:0]                 out_status_code
);
  import tssv_pkg::*;

  tssv_cmd_t cmd;
  tssv_sts_t sts;

  tssv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tssv_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_valid  (out_token_valid),
    .out_token_value  (out_token_value),
    .out_status_valid (out_status_valid),
    .out_status_code  (out_status_code)
  );

  // Every request carries a token or a status
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_valid || out_status_valid))
    else $error("empty output request");

  // A token field is zero when no token is carried
  a_tok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_token_valid) |-> (out_token_value == 32'd0))
    else $error("stale token value");

  // The header end starts the divider and blocks input
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> in_stall)
    else $error("input taken during divide");

endmodule

### sim/tssv_checker.sv
`timescale 1ns / 1ps
module tssv_checker
  import tssv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_file,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_token_valid,
  input  logic [31:0]      out_token_value,
  input  logic             out_status_valid,
  input  logic [2:0]       out_status_code,
  output int               pending,
  output int               fail_count,
  output int               checked
);

  typedef struct packed {
    logic        tok_v;
    logic [31:0] tok;
    logic        sts_v;
    logic [2:0]  sts;
  } shard_result_t;

  shard_result_t result_q[$];

  // Mirrored registers
  logic [32:0] vocab_lim;
  logic [63:0] ident_word [4];
  logic [31:0] bos_val;
  logic [31:0] eos_val;

  // Parser state
  phase_t      ph;
  logic [6:0]  idx;
  logic        magic_ok;
  logic        ident_ok;
  logic [31:0] ver;
  logic [31:0] flg;
  logic [63:0] seq_len;
  logic [63:0] tok_cnt;
  logic [63:0] smp_cnt;
  logic [63:0] seen;
  logic [31:0] asm_word;
  logic [31:0] crc;
  logic [31:0] first_tok;
  logic [31:0] last_tok;
  logic [63:0] foot;
  logic [2:0]  err;

  function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (32'hEDB8_8320 ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_parse();
    ph = PH_HEADER;
    idx = '0;
    magic_ok = 1'b1;
    ident_ok = 1'b1;
    ver = '0;
    flg = '0;
    seq_len = '0;
    tok_cnt = '0;
    smp_cnt = '0;
    seen = '0;
    asm_word = '0;
    crc = 32'hFFFF_FFFF;
    first_tok = '0;
    last_tok = '0;
    foot = '0;
    err = SC_OK;
  endtask

  task automatic halt(input logic [2:0] code);
    err = code;
    ph = PH_HALTED;
  endtask

  // Consume one header byte; run the header checks on the last one
  task automatic header_step(input logic [7:0] b);
    int i;
    int k;
    i = idx;
    crc = crc_next(crc, b);
    if (i < 8) begin
      if (b != SHARD_MARK[8*i +: 8]) magic_ok = 1'b0;
    end else if (i < 12) begin
      ver[8*(i-8) +: 8] = b;
    end else if (i < 16) begin
      flg[8*(i-12) +: 8] = b;
    end else if (i < 24) begin
      seq_len[8*(i-16) +: 8] = b;
    end else if (i < 32) begin
      tok_cnt[8*(i-24) +: 8] = b;
    end else if (i < 40) begin
      smp_cnt[8*(i-32) +: 8] = b;
    end else begin
      k = i - 40;
      if (b != ident_word[k >> 3][8*(k & 7) +: 8]) ident_ok = 1'b0;
    end
    if (i < 71) begin
      idx = idx + 1;
      return;
    end
    idx = '0;
    if (!magic_ok) halt(SC_CORRUPT);
    else if (ver != 32'd1) halt(SC_VERSION);
    else if (flg != 0 || seq_len == 0 || tok_cnt < 2 || smp_cnt == 0) halt(SC_CORRUPT);
    else if (smp_cnt != 64'd1 + (tok_cnt - 64'd2) / seq_len) halt(SC_CORRUPT);
    else if (!ident_ok) halt(SC_CONFIG);
    else if (tok_cnt > 64'h3FFF_FFFF_FFFF_FFFF) halt(SC_OVERFLOW);
    else if (vocab_lim == 0) halt(SC_CONFIG);
    else ph = PH_TOKENS;
  endtask

  // Advance the parser by one request and queue the result it causes
  task automatic predict_request(input logic [7:0] b, input logic eof);
    shard_result_t r;
    r = '0;
    case (ph)
      PH_HEADER: header_step(b);
      PH_TOKENS: begin
        crc = crc_next(crc, b);
        asm_word[8*idx[1:0] +: 8] = b;
        if (idx < 3) begin
          idx = idx + 1;
        end else begin
          idx = '0;
          if ({1'b0, asm_word} >= vocab_lim) begin
            halt(SC_CORRUPT);
          end else begin
            r.tok_v = 1'b1;
            r.tok = asm_word;
            if (seen == 0) first_tok = asm_word;
            last_tok = asm_word;
            seen = seen + 1;
            if (seen >= tok_cnt) ph = PH_FOOTER;
          end
          asm_word = '0;
        end
      end
      PH_FOOTER: begin
        foot[8*idx[2:0] +: 8] = b;
        if (idx < 7) begin
          idx = idx + 1;
        end else begin
          idx = '0;
          if (foot[31:0] != 32'd1 || foot[63:32] != ~crc) halt(SC_CORRUPT);
          else ph = PH_COMPLETE;
        end
      end
      PH_COMPLETE: halt(SC_CORRUPT);
      default: ;
    endcase
    if (eof) begin
      r.sts_v = 1'b1;
      if (err != SC_OK) r.sts = err;
      else if (ph != PH_COMPLETE) r.sts = SC_CORRUPT;
      else if (first_tok != bos_val || last_tok != eos_val) r.sts = SC_CONFIG;
      else r.sts = SC_OK;
      clear_parse();
    end
    if (r.tok_v || r.sts_v) result_q.push_back(r);
  endtask

  // Compare one delivered result against the oldest prediction
  task automatic check_result();
    shard_result_t exp_r;
    shard_result_t got;
    got = {out_token_valid, out_token_value, out_status_valid, out_status_code};
    checked++;
    if (result_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result: %p", got);
      return;
    end
    exp_r = result_q.pop_front();
    if (got.tok_v != exp_r.tok_v || got.tok != exp_r.tok || got.sts_v != exp_r.sts_v ||
        got.sts != exp_r.sts) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected tok_v=%0b tok=%h sts_v=%0b sts=%0d", exp_r.tok_v,
                 exp_r.tok, exp_r.sts_v, exp_r.sts);
        $display("          actual   tok_v=%0b tok=%h sts_v=%0b sts=%0d", got.tok_v,
                 got.tok, got.sts_v, got.sts);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      vocab_lim <= '0;
      for (int i = 0; i < 4; i++) ident_word[i] <= '0;
      bos_val <= 32'd1;
      eos_val <= 32'd2;
      clear_parse();
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_request(in_data_byte, in_end_of_file);
      if (out_valid && !out_stall) check_result();
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_VOCAB: vocab_lim <= cfg_data[32:0];
          REG_ID0:   ident_word[0] <= cfg_data;
          REG_ID1:   ident_word[1] <= cfg_data;
          REG_ID2:   ident_word[2] <= cfg_data;
          REG_ID3:   ident_word[3] <= cfg_data;
          REG_BOS:   bos_val <= cfg_data[31:0];
          REG_EOS:   eos_val <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
    pending <= result_q.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import tssv_pkg::*;

  localparam int TARGET_BYTES = 850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 80;

  typedef enum int {
    F_NONE, F_MAGIC, F_VERSION, F_FLAGS, F_SEQ_ZERO, F_FEW_TOKENS, F_SAMPLES,
    F_IDENTITY, F_OVERFLOW, F_RANGE, F_CHECKSUM_ID, F_CRC, F_TRAILING,
    F_TRUNCATED, F_BOUNDARY, F_NOISE
  } flaw_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_data_byte;
  logic             in_end_of_file;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             out_valid;
  logic             out_stall;
  logic             out_token_valid;
  logic [31:0]      out_token_value;
  logic             out_status_valid;
  logic [2:0]       out_status_code;
  int               pending;
  int               fail_count;
  int               checked;

  token_shard_stream_validator_top dut (.*);

  tssv_checker chk (.*);

  // Local copy of the register values, used to build files
  logic [32:0] vocab_v;
  logic [63:0] id_v [4];
  logic [31:0] bos_v;
  logic [31:0] eos_v;

  logic [7:0] file_q[$];
  int         bytes_sent;
  int         files_sent;
  int         cycles;
  bit         calm_in;
  bit         calm_out;
  int         stall_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver backpressure, with calm stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_out <= ~calm_out;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm_out && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  function automatic logic [31:0] rand_token();
    if (vocab_v == 0 || vocab_v > 33'hFFFF_FFFF) return $urandom();
    return $urandom() % vocab_v[31:0];
  endfunction

  function automatic logic [31:0] crc_of_file();
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    foreach (file_q[i]) begin
      c = c ^ {24'd0, file_q[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB8_8320 ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Build one shard file, well formed except for the chosen flaw
  task automatic build_file(input flaw_t f);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] n;
    logic [31:0] tok;
    logic [31:0] c;
    int          body;
    int          pos;
    file_q.delete();
    if (f == F_NOISE) begin
      repeat ($urandom_range(1, 20)) file_q.push_back($urandom());
      return;
    end
    t = $urandom_range(2, 6);
    s = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(1, 4)) : {$urandom(), $urandom()} | 1;
    n = 64'd1 + (t - 64'd2) / s;
    case (f)
      F_SEQ_ZERO:   s = 0;
      F_FEW_TOKENS: begin t = $urandom_range(0, 1); n = 1; end
      F_SAMPLES:    n = ($urandom_range(0, 1) && n > 1) ? n - 1 : n + $urandom_range(1, 3);
      F_OVERFLOW:   begin t = {2'b01, $urandom(), 30'($urandom())}; s = t; n = 1; end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) file_q.push_back(SHARD_MARK[8*i +: 8]);
    if (f == F_MAGIC) file_q[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    put_le((f == F_VERSION) ? 64'($urandom() | 32'h2) : 64'd1, 4);
    put_le((f == F_FLAGS) ? 64'(32'd1 << $urandom_range(0, 31)) : 64'd0, 4);
    put_le(s, 8);
    put_le(t, 8);
    put_le(n, 8);
    for (int i = 0; i < 4; i++) put_le(id_v[i], 8);
    if (f == F_IDENTITY) file_q[$urandom_range(40, 71)] ^= 8'(1 << $urandom_range(0, 7));
    body = (t <= 64) ? int'(t) : $urandom_range(0, 3);
    pos = $urandom_range(0, body > 0 ? body - 1 : 0);
    for (int i = 0; i < body; i++) begin
      tok = rand_token();
      if (i == 0) tok = bos_v;
      if (i == body - 1 && body >= 2) tok = eos_v;
      if (f == F_BOUNDARY && i == pos) tok = rand_token();
      if (f == F_RANGE && i == pos) begin
        tok = (vocab_v > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : vocab_v[31:0] + $urandom_range(0, 3);
      end
      put_le(64'(tok), 4);
    end
    c = ~crc_of_file();
    put_le((f == F_CHECKSUM_ID) ? 64'($urandom() | 32'h2) : 64'd1, 4);
    put_le((f == F_CRC) ? 64'(c ^ (32'd1 << $urandom_range(0, 31))) : 64'(c), 4);
    if (f == F_TRAILING) repeat ($urandom_range(1, 3)) file_q.push_back($urandom());
    if (f == F_TRUNCATED) begin
      pos = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > pos) void'(file_q.pop_back());
    end
  endtask

  // Offer one request and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!calm_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid for one cycle between files
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_file(input flaw_t f);
    build_file(f);
    if ($urandom_range(0, 3) == 0) calm_in = ~calm_in;
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    idle_input();
    files_sent++;
  endtask

  // Wait until the block has drained, including the header divider
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Pick a register setting for the next phase and write every register
  task automatic load_config(input int sel);
    logic [31:0] lim;
    case (sel % 4)
      0: vocab_v = 33'($urandom_range(3, 5000));
      1: vocab_v = 33'h1_0000_0000;
      2: vocab_v = 0;
      default: vocab_v = 33'($urandom_range(2, 3));
    endcase
    for (int i = 0; i < 4; i++) begin
      id_v[i] = (sel % 4 == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom(), $urandom()};
    end
    lim = (vocab_v == 0 || vocab_v > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : vocab_v[31:0] - 1;
    bos_v = (sel % 4 == 1) ? 32'd0 : ((lim == 32'hFFFF_FFFF) ? $urandom() : $urandom() % (lim + 1));
    eos_v = (sel % 4 == 1) ? 32'hFFFF_FFFF : ((lim == 32'hFFFF_FFFF) ? $urandom() : $urandom() % (lim + 1));
    write_reg(REG_VOCAB, 64'(vocab_v));
    write_reg(REG_ID0, id_v[0]);
    write_reg(REG_ID1, id_v[1]);
    write_reg(REG_ID2, id_v[2]);
    write_reg(REG_ID3, id_v[3]);
    write_reg(REG_BOS, 64'(bos_v));
    write_reg(REG_EOS, 64'(eos_v));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sel;
    flaw_t f;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_file = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_VOCAB;
    cfg_data = '0;
    cycles = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    bytes_sent = 0;
    files_sent = 0;
    vocab_v = 0;
    for (int i = 0; i < 4; i++) id_v[i] = '0;
    bos_v = 32'd1;
    eos_v = 32'd2;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone end byte, short files of extreme bytes, a header under reset config
    send_byte(8'h00, 1'b1);
    idle_input();
    for (int i = 0; i < 4; i++) send_byte(8'hFF, i == 3);
    idle_input();
    send_file(F_NONE);
    drain();
    load_config(1);
    send_file(F_NONE);
    send_file(F_BOUNDARY);
    drain();

    // Random files, register setting changed every few files
    sel = 0;
    while (bytes_sent < TARGET_BYTES) begin
      if (files_sent % 3 == 0) begin
        drain();
        sel++;
        load_config((sel == 2) ? 2 : $urandom_range(0, 3));
      end
      if ($urandom_range(0, 99) < 50) f = F_NONE;
      else f = flaw_t'($urandom_range(1, 15));
      send_file(f);
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    $display("sent %0d files, %0d bytes; checked %0d results", files_sent, bytes_sent,
             checked);
    $display("covered header, token, footer and trailing-byte errors over several settings");
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tssv_pkg.sv
rtl/core/tssv_ctrl.sv
rtl/core/tssv_datapath.sv
rtl/core/token_shard_stream_validator_top.sv
sim/tssv_checker.sv
sim/tb.sv
